/* src/pmod_pkg.sv */
package pmod_pkg;

    localparam int DIGIT_BANKS = 5;

    typedef enum logic [1:0] {
        KIND_PORT_A = 2'd0,
        KIND_PORT_C = 2'd1,
        KIND_PORT_B = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_GENERATION   = 2'd0,
        CFG_DIP_SWITCHES = 2'd1,
        CFG_LAMP_TICKS   = 2'd2,
        CFG_SOL_TICKS    = 2'd3
    } cfg_index_t;

    // strobe codes (upper nibble of a port A write)
    localparam logic [3:0] CODE_LATCH     = 4'd0;
    localparam logic [3:0] CODE_SOL_BANK0 = 4'd1;
    localparam logic [3:0] CODE_SOL_BANK1 = 4'd2;
    localparam logic [3:0] CODE_LAMP_LO   = 4'd3;
    localparam logic [3:0] CODE_SWITCH_LO = 4'd7;
    localparam logic [3:0] CODE_CLOCK_HI  = 4'd11;
    localparam logic [3:0] CODE_DIP_LO    = 4'd12;
    localparam logic [3:0] NIBBLE_CLEAR   = 4'hf;

    localparam logic [31:0] SOL_KEEP_MASK  = 32'hC000_8000;
    localparam logic [31:0] SOL_BANK1_BIT  = 32'h0001_0000;
    localparam logic [7:0]  LAMP_TICKS_RST = 8'd2;
    localparam logic [7:0]  SOL_TICKS_RST  = 8'd2;

    // 7448 style segment patterns
    localparam logic [7:0] SEG7448 [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7c, 8'h07,
        8'h7f, 8'h67, 8'h58, 8'h4c, 8'h62, 8'h69, 8'h78, 8'h00
    };

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] switch_rows;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [4:0]  switch_column;
        logic [63:0] lamp_matrix;
        logic [31:0] solenoid_state;
        logic        diag_led;
        logic        digit_write;
        logic [5:0]  digit_position;
        logic [7:0]  digit_pattern;
    } result_t;

    typedef struct packed {
        logic        generation;
        logic [31:0] dip_switches;
        logic [7:0]  lamp_publish_ticks;
        logic [7:0]  sol_publish_ticks;
    } cfg_t;

endpackage

/* src/pmod_if.sv */
interface pmod_item_if;
    logic              valid;
    logic              ready;
    pmod_pkg::kind_t   kind;
    logic [7:0]        data;
    logic [7:0]        switch_rows;

    modport source (output valid, kind, data, switch_rows, input ready);
    modport sink   (input valid, kind, data, switch_rows, output ready);
endinterface

interface pmod_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [4:0]  switch_column;
    logic [63:0] lamp_matrix;
    logic [31:0] solenoid_state;
    logic        diag_led;
    logic        digit_write;
    logic [5:0]  digit_position;
    logic [7:0]  digit_pattern;

    modport source (output valid, read_data, switch_column, lamp_matrix, solenoid_state,
                    diag_led, digit_write, digit_position, digit_pattern, input ready);
    modport sink   (input valid, read_data, switch_column, lamp_matrix, solenoid_state,
                    diag_led, digit_write, digit_position, digit_pattern, output ready);
endinterface

interface pmod_cfg_if;
    logic                 valid;
    logic                 ready;
    pmod_pkg::cfg_index_t index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/pinball_mpu_output_decoder_core.sv */
// path: an accepted transaction passes the input register, then the result register,
// and waits there while the result side holds ready low
// throughput: one transaction per cycle while the result side holds ready high, set by
// the single decode pass between the input register and the result register
// reset: rst_n clears the decoder state and valid flags (not the input and result data
// registers), loads the publish counters with one, and restores the configuration defaults
module pinball_mpu_output_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    pmod_item_if.sink  item,
    pmod_result_if.source result,
    pmod_cfg_if.sink   cfg
);

    pmod_pkg::cfg_t    cfg_regs;
    pmod_pkg::stage_t  stage;
    pmod_pkg::result_t out_data;
    logic              advance;
    logic              out_valid;

    pmod_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    pmod_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    pmod_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_regs),
        .stage     (stage),
        .out_ready (result.ready),
        .advance   (advance),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign result.valid          = out_valid;
    assign result.read_data      = out_data.read_data;
    assign result.switch_column  = out_data.switch_column;
    assign result.lamp_matrix    = out_data.lamp_matrix;
    assign result.solenoid_state = out_data.solenoid_state;
    assign result.diag_led       = out_data.diag_led;
    assign result.digit_write    = out_data.digit_write;
    assign result.digit_position = out_data.digit_position;
    assign result.digit_pattern  = out_data.digit_pattern;

endmodule

/* src/pmod_cfg_regs.sv */
module pmod_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    pmod_cfg_if.sink       cfg,
    output pmod_pkg::cfg_t regs
);

    pmod_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.generation         <= 1'b1;
            regs_reg.dip_switches       <= '0;
            regs_reg.lamp_publish_ticks <= pmod_pkg::LAMP_TICKS_RST;
            regs_reg.sol_publish_ticks  <= pmod_pkg::SOL_TICKS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pmod_pkg::CFG_GENERATION:   regs_reg.generation         <= cfg.data[0];
                pmod_pkg::CFG_DIP_SWITCHES: regs_reg.dip_switches       <= cfg.data;
                pmod_pkg::CFG_LAMP_TICKS:   regs_reg.lamp_publish_ticks <= cfg.data[7:0];
                pmod_pkg::CFG_SOL_TICKS:    regs_reg.sol_publish_ticks  <= cfg.data[7:0];
                default:                    regs_reg                    <= regs_reg;
            endcase
        end
    end

endmodule

/* src/pmod_in_stage.sv */
module pmod_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    pmod_item_if.sink        item,
    input  logic             advance,
    output pmod_pkg::stage_t stage
);

    logic            valid_reg;
    pmod_pkg::item_t item_reg;
    logic            take;

    assign item.ready = !valid_reg || advance;
    assign take       = item.valid && item.ready;

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind        <= item.kind;
            item_reg.data        <= item.data;
            item_reg.switch_rows <= item.switch_rows;
        end
    end

endmodule

/* src/pmod_engine.sv */
module pmod_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  pmod_pkg::cfg_t    cfg,
    input  pmod_pkg::stage_t  stage,
    input  logic              out_ready,
    output logic              advance,
    output logic              out_valid,
    output pmod_pkg::result_t out_data
);

    logic [7:0]  last_port_a_reg,     last_port_a_next;
    logic [4:0]  column_strobe_reg,   column_strobe_next;
    logic        display_enabled_reg, display_enabled_next;
    logic [2:0]  digit_column_reg,    digit_column_next;
    logic [2:0]  clock_bank_reg,      clock_bank_next;
    logic        latch_disarmed_reg,  latch_disarmed_next;
    logic        led_bit_reg,         led_bit_next;
    logic [31:0] sol_accum_reg,       sol_accum_next;
    logic [31:0] sol_pulsed_reg,      sol_pulsed_next;
    logic [31:0] sol_published_reg,   sol_published_next;
    logic [63:0] lamp_accum_reg,      lamp_accum_next;
    logic [63:0] lamp_published_reg,  lamp_published_next;
    logic [7:0]  lamp_countdown_reg,  lamp_countdown_next;
    logic [7:0]  sol_countdown_reg,   sol_countdown_next;

    logic              out_valid_reg;
    pmod_pkg::result_t result_reg, result_next;

    logic        fire;
    logic [3:0]  addr;
    logic [3:0]  code;
    logic [3:0]  switch_hi;
    logic [3:0]  clock_lo;
    logic [3:0]  lamp_hi;
    logic [3:0]  bank;
    logic [1:0]  lamp_group;
    logic [2:0]  switch_idx;
    logic [31:0] sol_bit;
    logic [2:0]  emit_column;
    logic [3:0]  read_strobe;
    logic [7:0]  dip_byte;

    assign advance   = !out_valid_reg || out_ready;
    assign fire      = stage.valid && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    assign addr        = stage.item.data[3:0];
    assign code        = stage.item.data[7:4];
    assign switch_hi   = cfg.generation ? 4'd11 : 4'd10;
    assign clock_lo    = cfg.generation ? 4'd7 : 4'd8;
    assign lamp_hi     = cfg.generation ? 4'd6 : 4'd5;
    assign bank        = code - clock_lo;
    assign lamp_group  = 2'(code - pmod_pkg::CODE_LAMP_LO);
    assign switch_idx  = 3'(code - pmod_pkg::CODE_SWITCH_LO);
    assign sol_bit     = (code == pmod_pkg::CODE_SOL_BANK1) ? (pmod_pkg::SOL_BANK1_BIT << addr)
                                                            : (32'd1 << addr);
    // column 7 is shown as column 0
    assign emit_column = (digit_column_reg != 3'd7) ? digit_column_reg : 3'd0;
    assign read_strobe = last_port_a_reg[7:4];
    assign dip_byte    = cfg.dip_switches[{read_strobe[1:0], 3'b000} +: 8];

    always_comb
    begin
        last_port_a_next     = last_port_a_reg;
        column_strobe_next   = column_strobe_reg;
        display_enabled_next = display_enabled_reg;
        digit_column_next    = digit_column_reg;
        clock_bank_next      = clock_bank_reg;
        latch_disarmed_next  = latch_disarmed_reg;
        led_bit_next         = led_bit_reg;
        sol_accum_next       = sol_accum_reg;
        sol_pulsed_next      = sol_pulsed_reg;
        sol_published_next   = sol_published_reg;
        lamp_accum_next      = lamp_accum_reg;
        lamp_published_next  = lamp_published_reg;
        lamp_countdown_next  = lamp_countdown_reg;
        sol_countdown_next   = sol_countdown_reg;
        result_next          = '0;

        unique case (stage.item.kind)
            pmod_pkg::KIND_PORT_A:
            begin
                last_port_a_next = stage.item.data;
                if (code == pmod_pkg::CODE_LATCH && !latch_disarmed_reg && display_enabled_reg)
                begin
                    result_next.digit_write    = 1'b1;
                    result_next.digit_position = {clock_bank_reg, emit_column};
                    result_next.digit_pattern  = pmod_pkg::SEG7448[addr];
                    latch_disarmed_next        = 1'b1;
                end
                if (code == pmod_pkg::CODE_SOL_BANK0 || code == pmod_pkg::CODE_SOL_BANK1)
                begin
                    if (addr == pmod_pkg::NIBBLE_CLEAR)
                    begin
                        sol_pulsed_next = sol_pulsed_reg & pmod_pkg::SOL_KEEP_MASK;
                        sol_accum_next  = sol_accum_reg & pmod_pkg::SOL_KEEP_MASK;
                    end
                    else
                    begin
                        sol_pulsed_next = (sol_pulsed_reg & pmod_pkg::SOL_KEEP_MASK) | sol_bit;
                        sol_accum_next  = sol_accum_reg | sol_bit;
                    end
                end
                if (code >= pmod_pkg::CODE_LAMP_LO && code <= lamp_hi)
                begin
                    lamp_accum_next = lamp_accum_reg
                                    | (64'(16'd1 << addr) << {lamp_group, 4'b0000});
                end
                if (code >= pmod_pkg::CODE_SWITCH_LO && code <= switch_hi)
                begin
                    column_strobe_next = 5'd1 << switch_idx;
                end
                if (code >= clock_lo && code <= pmod_pkg::CODE_CLOCK_HI && display_enabled_reg
                    && bank < 4'(pmod_pkg::DIGIT_BANKS))
                begin
                    clock_bank_next     = bank[2:0];
                    latch_disarmed_next = 1'b0;
                end
            end
            pmod_pkg::KIND_PORT_C:
            begin
                // column select is inverted, 7 means no change
                if (stage.item.data[2:0] != 3'd7)
                begin
                    digit_column_next = ~stage.item.data[2:0];
                end
                led_bit_next          = stage.item.data[3];
                display_enabled_next  = !stage.item.data[4];
                sol_accum_next[15]    = stage.item.data[7];
                sol_accum_next[30]    = stage.item.data[5];
                sol_accum_next[31]    = stage.item.data[6];
            end
            pmod_pkg::KIND_PORT_B:
            begin
                result_next.read_data = (read_strobe >= pmod_pkg::CODE_DIP_LO)
                                      ? dip_byte : stage.item.switch_rows;
            end
            pmod_pkg::KIND_TICK:
            begin
                if (lamp_countdown_reg <= 8'd1)
                begin
                    lamp_published_next = lamp_accum_reg;
                    lamp_accum_next     = '0;
                    lamp_countdown_next = cfg.lamp_publish_ticks;
                end
                else
                begin
                    lamp_countdown_next = lamp_countdown_reg - 8'd1;
                end
                if (sol_countdown_reg <= 8'd1)
                begin
                    sol_published_next = sol_accum_reg;
                    sol_accum_next     = sol_pulsed_reg;
                    sol_countdown_next = cfg.sol_publish_ticks;
                end
                else
                begin
                    sol_countdown_next = sol_countdown_reg - 8'd1;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase

        result_next.switch_column  = column_strobe_next;
        result_next.lamp_matrix    = lamp_published_next;
        result_next.solenoid_state = sol_published_next;
        result_next.diag_led       = led_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_port_a_reg     <= '0;
            column_strobe_reg   <= '0;
            display_enabled_reg <= 1'b0;
            digit_column_reg    <= '0;
            clock_bank_reg      <= '0;
            latch_disarmed_reg  <= 1'b0;
            led_bit_reg         <= 1'b0;
            sol_accum_reg       <= '0;
            sol_pulsed_reg      <= '0;
            sol_published_reg   <= '0;
            lamp_accum_reg      <= '0;
            lamp_published_reg  <= '0;
            lamp_countdown_reg  <= pmod_pkg::LAMP_TICKS_RST - 8'd1;
            sol_countdown_reg   <= pmod_pkg::SOL_TICKS_RST - 8'd1;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= stage.valid;
            end
            if (fire)
            begin
                last_port_a_reg     <= last_port_a_next;
                column_strobe_reg   <= column_strobe_next;
                display_enabled_reg <= display_enabled_next;
                digit_column_reg    <= digit_column_next;
                clock_bank_reg      <= clock_bank_next;
                latch_disarmed_reg  <= latch_disarmed_next;
                led_bit_reg         <= led_bit_next;
                sol_accum_reg       <= sol_accum_next;
                sol_pulsed_reg      <= sol_pulsed_next;
                sol_published_reg   <= sol_published_next;
                lamp_accum_reg      <= lamp_accum_next;
                lamp_published_reg  <= lamp_published_next;
                lamp_countdown_reg  <= lamp_countdown_next;
                sol_countdown_reg   <= sol_countdown_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* src/pmod_checker.sv */
module pmod_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [4:0] switch_column,
    input logic       digit_write,
    input logic [5:0] digit_position,
    input logic [7:0] digit_pattern
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result valid dropped before transaction");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(digit_pattern) && $stable(digit_position)
                            && $stable(switch_column))
        else $error("result payload changed while stalled");

    a_no_digit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !digit_write |-> digit_position == 6'd0 && digit_pattern == 8'd0)
        else $error("digit fields set without digit write");

    a_column_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $onehot0(switch_column))
        else $error("switch column not one-hot");

    // column 7 is folded to 0, banks stop below the bank count
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid && digit_write |-> digit_position < 6'(pmod_pkg::DIGIT_BANKS * 8)
                                 && digit_position[2:0] != 3'd7)
        else $error("digit position out of range");

endmodule

bind pinball_mpu_output_decoder_core pmod_checker u_pmod_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (result.valid),
    .ready          (result.ready),
    .switch_column  (result.switch_column),
    .digit_write    (result.digit_write),
    .digit_position (result.digit_position),
    .digit_pattern  (result.digit_pattern)
);

/* verif/pmod_decoder_checker.sv */
module pmod_decoder_checker
    import pmod_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    pmod_item_if   item,
    pmod_result_if result,
    pmod_cfg_if    cfg,
    output int     fail_count,
    output int     pending,
    output int     results_checked,
    output int     digits_latched
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] KEEP_ON_RELOAD = 32'hC000_8000;

    // segment patterns, digit 15 in the top byte down to digit 0 in the bottom byte
    localparam logic [127:0] SEGMENTS = {
        8'h00, 8'h78, 8'h69, 8'h62, 8'h4c, 8'h58, 8'h67, 8'h7f,
        8'h07, 8'h7c, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
    };

    cfg_t        settings;
    logic [7:0]  last_port_a;
    logic [4:0]  column_strobe;
    logic        display_on;
    logic [2:0]  digit_column;
    logic [2:0]  clock_bank;
    logic        latch_disarmed;
    logic        led;
    logic [31:0] sol_accum;
    logic [31:0] sol_pulsed;
    logic [31:0] sol_published;
    logic [63:0] lamp_accum;
    logic [63:0] lamp_published;
    logic [7:0]  lamp_countdown;
    logic [7:0]  sol_countdown;

    result_t decoded_outputs[$];
    result_t want;
    result_t got;

    task automatic decode_access(input kind_t k, input logic [7:0] d,
                                 input logic [7:0] rows, output result_t r);
        logic [3:0]  nib;
        logic [3:0]  code;
        logic [3:0]  clk_lo;
        logic [3:0]  sw_hi;
        logic [3:0]  lamp_hi;
        logic [2:0]  column;
        logic [31:0] sol_bit;
        logic [15:0] lamp_bit;
        int          bank;
        r = '0;
        case (k)
            KIND_PORT_A:
            begin
                nib     = d[3:0];
                code    = d[7:4];
                clk_lo  = settings.generation ? 4'd7 : 4'd8;
                sw_hi   = settings.generation ? 4'd11 : 4'd10;
                lamp_hi = settings.generation ? 4'd6 : 4'd5;
                last_port_a = d;
                if (code == CODE_LATCH && !latch_disarmed && display_on)
                begin
                    column = (digit_column != 3'd7) ? digit_column : 3'd0;
                    r.digit_write    = 1'b1;
                    r.digit_position = {clock_bank, column};
                    r.digit_pattern  = SEGMENTS[{nib, 3'b000} +: 8];
                    latch_disarmed   = 1'b1;
                end
                if (code == CODE_SOL_BANK0 || code == CODE_SOL_BANK1)
                begin
                    if (nib == NIBBLE_CLEAR)
                    begin
                        sol_pulsed &= KEEP_ON_RELOAD;
                        sol_accum  &= KEEP_ON_RELOAD;
                    end
                    else
                    begin
                        sol_bit = (code == CODE_SOL_BANK1) ? (32'h0001_0000 << nib)
                                                           : (32'h0000_0001 << nib);
                        sol_pulsed = (sol_pulsed & KEEP_ON_RELOAD) | sol_bit;
                        sol_accum  = sol_accum | sol_bit;
                    end
                end
                if (code >= CODE_LAMP_LO && code <= lamp_hi)
                begin
                    lamp_bit   = 16'd1 << nib;
                    lamp_accum = lamp_accum
                               | ({48'd0, lamp_bit} << {code - CODE_LAMP_LO, 4'b0000});
                end
                if (code >= CODE_SWITCH_LO && code <= sw_hi)
                    column_strobe = 5'd1 << (code - CODE_SWITCH_LO);
                if (code >= clk_lo && code <= CODE_CLOCK_HI && display_on)
                begin
                    bank = code - clk_lo;
                    if (bank < DIGIT_BANKS)
                    begin
                        clock_bank     = bank[2:0];
                        latch_disarmed = 1'b0;
                    end
                end
            end
            KIND_PORT_C:
            begin
                if (d[2:0] != 3'd7)
                    digit_column = 3'd7 - d[2:0];
                led           = d[3];
                display_on    = !d[4];
                sol_accum[15] = d[7];
                sol_accum[30] = d[5];
                sol_accum[31] = d[6];
            end
            KIND_PORT_B:
            begin
                code = last_port_a[7:4];
                r.read_data = (code >= CODE_DIP_LO)
                            ? settings.dip_switches[{code - CODE_DIP_LO, 3'b000} +: 8]
                            : rows;
            end
            default:
            begin
                if (lamp_countdown <= 8'd1)
                begin
                    lamp_published = lamp_accum;
                    lamp_accum     = '0;
                    lamp_countdown = settings.lamp_publish_ticks;
                end
                else
                    lamp_countdown--;
                if (sol_countdown <= 8'd1)
                begin
                    sol_published = sol_accum;
                    sol_accum     = sol_pulsed;
                    sol_countdown = settings.sol_publish_ticks;
                end
                else
                    sol_countdown--;
            end
        endcase
        r.switch_column  = column_strobe;
        r.lamp_matrix    = lamp_published;
        r.solenoid_state = sol_published;
        r.diag_led       = led;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.generation         = 1'b1;
            settings.dip_switches       = '0;
            settings.lamp_publish_ticks = 8'd2;
            settings.sol_publish_ticks  = 8'd2;
            last_port_a     = '0;
            column_strobe   = '0;
            display_on      = 1'b0;
            digit_column    = '0;
            clock_bank      = '0;
            latch_disarmed  = 1'b0;
            led             = 1'b0;
            sol_accum       = '0;
            sol_pulsed      = '0;
            sol_published   = '0;
            lamp_accum      = '0;
            lamp_published  = '0;
            lamp_countdown  = 8'd1;
            sol_countdown   = 8'd1;
            decoded_outputs.delete();
            fail_count      = 0;
            pending         = 0;
            results_checked = 0;
            digits_latched  = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.read_data      = result.read_data;
                got.switch_column  = result.switch_column;
                got.lamp_matrix    = result.lamp_matrix;
                got.solenoid_state = result.solenoid_state;
                got.diag_led       = result.diag_led;
                got.digit_write    = result.digit_write;
                got.digit_position = result.digit_position;
                got.digit_pattern  = result.digit_pattern;
                if (decoded_outputs.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result transaction with nothing expected, actual 0x%0h",
                             $time, got);
                end
                else
                begin
                    want = decoded_outputs.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("switch_column", want.switch_column, got.switch_column);
                    check_field("lamp_matrix", want.lamp_matrix, got.lamp_matrix);
                    check_field("solenoid_state", want.solenoid_state, got.solenoid_state);
                    check_field("diag_led", want.diag_led, got.diag_led);
                    check_field("digit_write", want.digit_write, got.digit_write);
                    check_field("digit_position", want.digit_position, got.digit_position);
                    check_field("digit_pattern", want.digit_pattern, got.digit_pattern);
                    results_checked++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_GENERATION:   settings.generation         = cfg.data[0];
                    CFG_DIP_SWITCHES: settings.dip_switches       = cfg.data;
                    CFG_LAMP_TICKS:   settings.lamp_publish_ticks = cfg.data[7:0];
                    default:          settings.sol_publish_ticks  = cfg.data[7:0];
                endcase
            end
            if (item.valid && item.ready)
            begin
                decode_access(item.kind, item.data, item.switch_rows, want);
                if (want.digit_write)
                    digits_latched++;
                decoded_outputs.push_back(want);
            end
            pending = decoded_outputs.size();
        end
    end

endmodule

/* verif/tb_pinball_mpu_output_decoder_core.sv */
module tb_pinball_mpu_output_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pmod_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady_flow;
    logic cur_generation;
    int   fail_count;
    int   pending;
    int   results_checked;
    int   digits_latched;
    int   accesses_by_kind [4];
    int   reg_writes;
    int   settings_used;
    int   idle_cycles = 0;

    pmod_item_if   item_bus ();
    pmod_result_if result_bus ();
    pmod_cfg_if    cfg_bus ();

    pinball_mpu_output_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    pmod_decoder_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_bus),
        .result          (result_bus),
        .cfg             (cfg_bus),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .digits_latched  (digits_latched)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic send_access(input kind_t k, input logic [7:0] d, input logic [7:0] rows);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            item_bus.valid <= 1'b0;
        end
        @(negedge clk);
        item_bus.valid       <= 1'b1;
        item_bus.kind        <= k;
        item_bus.data        <= d;
        item_bus.switch_rows <= rows;
        do
            @(posedge clk);
        while (!item_bus.ready);
        accesses_by_kind[k]++;
    endtask

    // drop valid and wait until every result has come back
    task automatic settle();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic apply_settings(input logic gen, input logic [31:0] dip,
                                  input logic [7:0] lamp_ticks, input logic [7:0] sol_ticks);
        settle();
        write_reg(CFG_GENERATION, {31'd0, gen});
        write_reg(CFG_DIP_SWITCHES, dip);
        write_reg(CFG_LAMP_TICKS, {24'd0, lamp_ticks});
        write_reg(CFG_SOL_TICKS, {24'd0, sol_ticks});
        cur_generation = gen;
        settings_used++;
    endtask

    task automatic run_random_accesses(input int count);
        int         sent;
        int         pick;
        logic [3:0] code;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 64 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // display sequence: mostly enable, clock a bank, at times a port B read or tick, then latch a digit
                if ($urandom_range(0, 3) != 0)
                begin
                    send_access(KIND_PORT_C, {3'($urandom), 1'b0, 4'($urandom)}, 8'($urandom));
                    sent++;
                end
                code = 4'($urandom_range(cur_generation ? 7 : 8, 11));
                send_access(KIND_PORT_A, {code, 4'($urandom)}, 8'($urandom));
                sent++;
                if ($urandom_range(0, 3) == 0)
                begin
                    send_access(kind_t'($urandom_range(2, 3)), 8'($urandom), 8'($urandom));
                    sent++;
                end
                send_access(KIND_PORT_A, {CODE_LATCH, 4'($urandom)}, 8'($urandom));
                sent++;
            end
            else if (pick < 45)
            begin
                send_access(KIND_PORT_A, 8'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 55)
            begin
                code = $urandom_range(0, 1) ? CODE_SOL_BANK1 : CODE_SOL_BANK0;
                send_access(KIND_PORT_A,
                            {code, ($urandom_range(0, 4) == 0) ? NIBBLE_CLEAR : 4'($urandom)},
                            8'($urandom));
                sent++;
            end
            else if (pick < 63)
            begin
                send_access(KIND_PORT_C, 8'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 73)
            begin
                code = 4'($urandom_range(12, 15));
                send_access(KIND_PORT_A, {code, 4'($urandom)}, 8'($urandom));
                send_access(KIND_PORT_B, 8'($urandom), 8'($urandom));
                sent += 2;
            end
            else if (pick < 80)
            begin
                send_access(KIND_PORT_B, 8'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 95)
            begin
                send_access(KIND_TICK, 8'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                send_access(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            repeat (stall)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b0;
            end
            @(negedge clk);
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        steady_flow          = 1'b0;
        cur_generation       = 1'b1;
        reg_writes           = 0;
        settings_used        = 1;
        item_bus.valid       = 1'b0;
        item_bus.kind        = KIND_TICK;
        item_bus.data        = '0;
        item_bus.switch_rows = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_GENERATION;
        cfg_bus.data         = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: second board map, publish every two ticks
        send_access(KIND_PORT_C, 8'h07, 8'h00);    // display on, column left at zero
        send_access(KIND_PORT_A, 8'h00, 8'h00);    // latch armed out of reset, bank 0
        send_access(KIND_PORT_A, 8'h75, 8'h00);    // clock bank 0, switch column 0
        send_access(KIND_PORT_C, 8'h00, 8'h00);    // digit column 7
        send_access(KIND_PORT_A, 8'h09, 8'h00);    // column 7 shows as column 0
        send_access(KIND_PORT_A, 8'hb2, 8'h00);    // clock bank 4, switch column 4
        send_access(KIND_PORT_C, 8'h01, 8'h00);
        send_access(KIND_PORT_A, 8'h0e, 8'h00);
        send_access(KIND_PORT_A, 8'h0f, 8'h00);    // latch already used
        send_access(KIND_PORT_A, 8'h9c, 8'h00);
        send_access(KIND_PORT_C, 8'hf8, 8'h00);    // display off, led and direct solenoids
        send_access(KIND_PORT_A, 8'h04, 8'h00);    // latch held while display is off
        send_access(KIND_PORT_C, 8'h02, 8'h00);
        send_access(KIND_PORT_A, 8'h03, 8'h00);
        send_access(KIND_PORT_C, 8'hf0, 8'h00);
        send_access(KIND_PORT_A, 8'h83, 8'h00);    // clock ignored with display off
        send_access(KIND_PORT_A, 8'h10, 8'h00);
        send_access(KIND_PORT_A, 8'h2e, 8'h00);
        send_access(KIND_PORT_A, 8'h1f, 8'h00);    // clear nibble
        send_access(KIND_PORT_A, 8'h30, 8'h00);
        send_access(KIND_PORT_A, 8'h4f, 8'h00);
        send_access(KIND_PORT_A, 8'h5a, 8'h00);
        send_access(KIND_PORT_A, 8'h67, 8'hff);
        send_access(KIND_TICK, 8'hff, 8'h00);
        send_access(KIND_TICK, 8'h00, 8'h00);
        send_access(KIND_TICK, 8'h00, 8'h00);
        send_access(KIND_PORT_B, 8'h00, 8'ha5);
        send_access(KIND_PORT_A, 8'hf0, 8'h00);
        send_access(KIND_PORT_B, 8'h00, 8'h5a);

        run_random_accesses(200);
        apply_settings(1'b0, $urandom, 8'd1, 8'd1);
        run_random_accesses(275);
        apply_settings(1'b1, 32'hffff_ffff, 8'd255, 8'd255);
        run_random_accesses(275);
        apply_settings(1'b0, 32'h0000_0000, 8'd0, 8'd0);     // zero period acts as one
        run_random_accesses(275);
        apply_settings(1'b1, $urandom, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
        run_random_accesses(275);
        apply_settings(1'b0, $urandom, 8'd3, 8'd255);
        run_random_accesses(275);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d accesses: %0d port A, %0d port C, %0d port B, %0d ticks",
                 accesses_by_kind[0] + accesses_by_kind[1] + accesses_by_kind[2]
                 + accesses_by_kind[3], accesses_by_kind[0], accesses_by_kind[1],
                 accesses_by_kind[2], accesses_by_kind[3]);
        $display("%0d register writes over %0d settings, %0d results checked, %0d digits",
                 reg_writes, settings_used, results_checked, digits_latched);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
